### sv/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and microcode for the anti-windup pid controller
// control word layout, register map, clamp codes and the step program rom
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned STEP_W = 4;
  localparam int unsigned OPA_W  = 35;
  localparam int unsigned HALF_W = 17;
  localparam int unsigned PROD_W = 50;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned EXC_W  = 34;
  localparam int unsigned ADDR_W = 5;

  localparam logic [STEP_W-1:0] STEP_START = '0;

  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_KW    = 3'd3;
  localparam logic [2:0] REG_MAX_U = 3'd4;
  localparam logic [2:0] REG_MIN_U = 3'd5;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_MAX  = 2'd1;
  localparam logic [1:0] CLAMP_MIN  = 2'd2;

  typedef enum logic [1:0] {
    A_HOLD,
    A_EXCESS,
    A_EI,
    A_DIFF
  } a_sel_e;

  typedef enum logic [1:0] {
    G_KP,
    G_KI,
    G_KD,
    G_KW
  } g_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_P,
    WR_INTEG,
    WR_U,
    WR_OUT
  } wr_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    a_sel_e  a_sel;
    g_sel_e  g_sel;
    logic    hi;
    acc_op_e acc_op;
    wr_e     wr;
    jmp_e    jmp;
  } ctrl_t;

  // step program: four multiplies, each as low half, high half, accumulate
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{a_sel: A_HOLD, g_sel: G_KP, hi: 1'b0, acc_op: ACC_HOLD,
          wr: WR_NONE, jmp: JMP_NEXT};
    case (step)
      4'd0: begin
        c.jmp = JMP_WAIT_IN;
      end
      4'd1: begin
        c.g_sel = G_KP;
      end
      4'd2: begin
        c.g_sel  = G_KP;
        c.hi     = 1'b1;
        c.acc_op = ACC_LOAD;
      end
      4'd3: begin
        c.acc_op = ACC_ADD;
        c.a_sel  = A_EXCESS;
      end
      4'd4: begin
        c.wr    = WR_P;
        c.g_sel = G_KW;
      end
      4'd5: begin
        c.g_sel  = G_KW;
        c.hi     = 1'b1;
        c.acc_op = ACC_LOAD;
      end
      4'd6: begin
        c.acc_op = ACC_ADD;
      end
      4'd7: begin
        c.a_sel = A_EI;
      end
      4'd8: begin
        c.g_sel = G_KI;
      end
      4'd9: begin
        c.g_sel  = G_KI;
        c.hi     = 1'b1;
        c.acc_op = ACC_LOAD;
      end
      4'd10: begin
        c.acc_op = ACC_ADD;
        c.a_sel  = A_DIFF;
      end
      4'd11: begin
        c.wr    = WR_INTEG;
        c.g_sel = G_KD;
      end
      4'd12: begin
        c.g_sel  = G_KD;
        c.hi     = 1'b1;
        c.acc_op = ACC_LOAD;
      end
      4'd13: begin
        c.acc_op = ACC_ADD;
      end
      4'd14: begin
        c.wr = WR_U;
      end
      4'd15: begin
        c.wr  = WR_OUT;
        c.jmp = JMP_WAIT_OUT;
      end
      default: begin
        c.jmp = JMP_NEXT;
      end
    endcase
    return c;
  endfunction

endpackage

### sv/pid_antiwindup_controller_top.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_top: pid controller with back-calculation anti-windup
// one error sample in, one clamped drive value and clamp flag out
// ----------------------------------------------------------------------------
// schedule: a 16-step microcode program runs four two-pass multiplies on one
//   shared 18x32 multiplier; a new error sample is accepted only after the
//   previous result has been loaded into the output register, which waits
//   while that register still holds a stalled result
// reset: gains and limits return to defaults, integrator, last error and
//   clamp excess clear, sequencer returns to its idle step
module pid_antiwindup_controller_top import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [ADDR_W-1:0] paddr,
  input  logic        [DATA_W-1:0] pwdata,
  output logic        [DATA_W-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] error_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] drive_o,
  output logic        [1:0]        clamp_state_o
);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] LIM_ONE  = DATA_W'(1) << FRAC_BITS;

  logic [GAIN_W-1:0] kp_q, ki_q, kd_q, kw_q;
  logic signed [DATA_W-1:0] max_u_q, min_u_q;

  logic signed [DATA_W-1:0] err_q, last_err_q, integ_q, p_q;
  logic signed [EXC_W-1:0]  excess_q, excess_d;
  logic signed [EXC_W-1:0]  u_q, u_d;
  logic signed [OPA_W-1:0]  opa_q, opa_d;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic [1:0]               clamp_state_q, clamp_state_d;

  ctrl_t                    ctrl;
  logic                     out_free, out_load, in_xfer, cfg_wr;
  logic [GAIN_W-1:0]        gain;
  logic signed [DATA_W-1:0] res, ei, integ_d;
  logic signed [DATA_W:0]   ei_w, integ_w;
  logic signed [EXC_W:0]    exc_w;
  logic signed [EXC_W-1:0]  max_x, min_x;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= GAIN_ONE;
      ki_q    <= '0;
      kd_q    <= '0;
      kw_q    <= GAIN_ONE;
      max_u_q <= LIM_ONE;
      min_u_q <= DATA_W'(0) - LIM_ONE;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_KP:    kp_q    <= pwdata[GAIN_W-1:0];
        REG_KI:    ki_q    <= pwdata[GAIN_W-1:0];
        REG_KD:    kd_q    <= pwdata[GAIN_W-1:0];
        REG_KW:    kw_q    <= pwdata[GAIN_W-1:0];
        REG_MAX_U: max_u_q <= pwdata;
        REG_MIN_U: min_u_q <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_KP:    prdata = {1'b0, kp_q};
      REG_KI:    prdata = {1'b0, ki_q};
      REG_KD:    prdata = {1'b0, kd_q};
      REG_KW:    prdata = {1'b0, kw_q};
      REG_MAX_U: prdata = max_u_q;
      REG_MIN_U: prdata = min_u_q;
      default:   prdata = '0;
    endcase
  end

  // sequencer and shared multiplier
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (ctrl.wr == WR_OUT) && out_free;
  assign in_stall_o = ctrl.jmp != JMP_WAIT_IN;
  assign in_xfer    = in_valid_i && !in_stall_o;

  pidaw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (ctrl.g_sel)
      G_KP:    gain = kp_q;
      G_KI:    gain = ki_q;
      G_KD:    gain = kd_q;
      G_KW:    gain = kw_q;
      default: gain = kp_q;
    endcase
  end

  pidaw_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .opa_i  (opa_q),
    .gain_i (gain),
    .res_o  (res)
  );

  // integrator input: error minus anti-windup term
  assign ei_w = {err_q[DATA_W-1], err_q} - {res[DATA_W-1], res};
  assign ei   = (ei_w[DATA_W] != ei_w[DATA_W-1]) ?
                {ei_w[DATA_W], {(DATA_W-1){!ei_w[DATA_W]}}} : ei_w[DATA_W-1:0];

  assign integ_w = {integ_q[DATA_W-1], integ_q} + {res[DATA_W-1], res};
  assign integ_d = (integ_w[DATA_W] != integ_w[DATA_W-1]) ?
                   {integ_w[DATA_W], {(DATA_W-1){!integ_w[DATA_W]}}} :
                   integ_w[DATA_W-1:0];

  assign u_d = {{2{p_q[DATA_W-1]}}, p_q} + {{2{integ_q[DATA_W-1]}}, integ_q}
             + {{2{res[DATA_W-1]}}, res};

  always_comb begin
    opa_d = opa_q;
    if (in_xfer) begin
      opa_d = {{(OPA_W-DATA_W){error_sample_i[DATA_W-1]}}, error_sample_i};
    end else begin
      case (ctrl.a_sel)
        A_EXCESS: opa_d = {excess_q[EXC_W-1], excess_q};
        A_EI:     opa_d = {{(OPA_W-DATA_W){ei[DATA_W-1]}}, ei};
        A_DIFF:   opa_d = {{(OPA_W-DATA_W){err_q[DATA_W-1]}}, err_q}
                        - {{(OPA_W-DATA_W){last_err_q[DATA_W-1]}}, last_err_q};
        default:  opa_d = opa_q;
      endcase
    end
  end

  // output clamp, max limit tested first
  assign max_x = {{2{max_u_q[DATA_W-1]}}, max_u_q};
  assign min_x = {{2{min_u_q[DATA_W-1]}}, min_u_q};

  always_comb begin
    if (u_q > max_x) begin
      drive_d       = max_u_q;
      clamp_state_d = CLAMP_MAX;
    end else if (u_q < min_x) begin
      drive_d       = min_u_q;
      clamp_state_d = CLAMP_MIN;
    end else begin
      drive_d       = u_q[DATA_W-1:0];
      clamp_state_d = CLAMP_NONE;
    end
  end

  assign exc_w    = {u_q[EXC_W-1], u_q} - {{(EXC_W+1-DATA_W){drive_d[DATA_W-1]}}, drive_d};
  assign excess_d = (exc_w[EXC_W] != exc_w[EXC_W-1]) ?
                    {exc_w[EXC_W], {(EXC_W-1){!exc_w[EXC_W]}}} : exc_w[EXC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_err_q  <= '0;
      excess_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.wr == WR_INTEG) begin
        integ_q <= integ_d;
      end
      if (out_load) begin
        last_err_q  <= err_q;
        excess_q    <= excess_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    if (in_xfer) begin
      err_q <= error_sample_i;
    end
    if (ctrl.wr == WR_P) begin
      p_q <= res;
    end
    if (ctrl.wr == WR_U) begin
      u_q <= u_d;
    end
    if (out_load) begin
      drive_q       <= drive_d;
      clamp_state_q <= clamp_state_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign clamp_state_o = clamp_state_q;

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("sequencer stayed idle after input transfer");

  a_flag_matches_excess: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((clamp_state_q == CLAMP_NONE) == (excess_q == '0)))
    else $error("clamp flag disagrees with stored excess");

  a_flag_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (clamp_state_q == CLAMP_NONE || clamp_state_q == CLAMP_MAX ||
                  clamp_state_q == CLAMP_MIN))
    else $error("invalid clamp flag code");

endmodule

### sv/pidaw_seq.sv
// ----------------------------------------------------------------------------
// pidaw_seq: microcode sequencer
// step counter over the program rom with wait-for-input and wait-for-output
// ----------------------------------------------------------------------------
module pidaw_seq import pidaw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             ctrl;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    pc_d = pc_q;
    case (ctrl.jmp)
      JMP_NEXT: begin
        pc_d = pc_q + 1'b1;
      end
      JMP_WAIT_IN: begin
        if (in_valid_i) begin
          pc_d = pc_q + 1'b1;
        end
      end
      JMP_WAIT_OUT: begin
        if (out_free_i) begin
          pc_d = STEP_START;
        end
      end
      default: begin
        pc_d = STEP_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_START;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### sv/pidaw_mac.sv
// ----------------------------------------------------------------------------
// pidaw_mac: shared multiply-accumulate unit
// operand times gain in two halves, exact sum, floor shift, 32-bit saturation
// ----------------------------------------------------------------------------
module pidaw_mac import pidaw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  logic signed [OPA_W-1:0]  opa_i,
  input  logic        [GAIN_W-1:0] gain_i,
  output logic signed [DATA_W-1:0] res_o
);

  logic signed [HALF_W:0]   half;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  sh;
  logic                     ovf;

  assign half   = ctrl_i.hi ? opa_i[OPA_W-1:HALF_W] : {1'b0, opa_i[HALF_W-1:0]};
  assign prod_d = half * $signed({1'b0, gain_i});

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      ACC_ADD:  acc_d = acc_q + $signed({prod_q[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}});
      default:  acc_d = acc_q;
    endcase
  end

  // upper bits of the shifted sum must all equal the sign to fit 32 bits
  assign sh  = acc_q >>> FRAC_BITS;
  assign ovf = !((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1]));

  always_comb begin
    if (ovf) begin
      res_o = sh[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res_o = sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule
